// ===== src/rv32ex_pkg.sv =====
`default_nettype none

package rv32ex_pkg;

    // Major opcodes, instruction bits 6:0
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    // funct3 codes of the ALU group
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // funct3 codes of conditional branches
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // funct3 codes of CSR operations (register and immediate forms)
    localparam logic [2:0] F3_CSRRW  = 3'd1;
    localparam logic [2:0] F3_CSRRS  = 3'd2;
    localparam logic [2:0] F3_CSRRC  = 3'd3;
    localparam logic [2:0] F3_CSRRWI = 3'd5;
    localparam logic [2:0] F3_CSRRSI = 3'd6;
    localparam logic [2:0] F3_CSRRCI = 3'd7;

    localparam logic [31:0] INSN_BYTES = 32'd4;

    typedef struct packed {
        logic [6:0]  action;
        logic [2:0]  funct3;
        logic [6:0]  funct7;
        logic [31:0] left;
        logic [31:0] right;
        logic [31:0] third;
        logic [31:0] pc;
        logic        item_valid;
        logic        dest_used;
        logic [4:0]  dest_reg;
    } op_t;

    typedef struct packed {
        logic [31:0] alu_result;
        logic [31:0] branch_target;
        logic        branch_taken;
        logic [31:0] side_data;
        logic        is_load;
        logic [4:0]  dest_reg;
        logic        dest_write;
        logic        valid;
    } res_t;

endpackage

`default_nettype wire

// ===== src/rv32ex_alu.sv =====
`default_nettype none

module rv32ex_alu (
    input  rv32ex_pkg::op_t  op,
    output rv32ex_pkg::res_t res
);
    import rv32ex_pkg::*;

    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] sum;
    logic [31:0] diff;
    logic [4:0]  shamt;
    logic        lt_s;
    logic        lt_u;
    logic        sub_sel;
    logic [31:0] alu_val;
    logic        cmp_taken;

    assign a     = op.left;
    assign b     = op.right;
    assign sum   = a + b;
    assign diff  = a - b;
    assign shamt = b[4:0];
    assign lt_s  = $signed(a) < $signed(b);
    assign lt_u  = a < b;

    // SUB only exists in the register form
    assign sub_sel = (op.action == OPC_OP) && op.funct7[5];

    always_comb
    begin
        case (op.funct3)
            F3_ADD:  alu_val = sub_sel ? diff : sum;
            F3_SLL:  alu_val = a << shamt;
            F3_SLT:  alu_val = {31'd0, lt_s};
            F3_SLTU: alu_val = {31'd0, lt_u};
            F3_XOR:  alu_val = a ^ b;
            F3_SR:   alu_val = op.funct7[5] ? $unsigned($signed(a) >>> shamt) : (a >> shamt);
            F3_OR:   alu_val = a | b;
            F3_AND:  alu_val = a & b;
            default: alu_val = a & b;
        endcase
    end

    always_comb
    begin
        case (op.funct3)
            F3_BEQ:  cmp_taken = (a == b);
            F3_BNE:  cmp_taken = (a != b);
            F3_BLT:  cmp_taken = lt_s;
            F3_BGE:  cmp_taken = !lt_s;
            F3_BLTU: cmp_taken = lt_u;
            F3_BGEU: cmp_taken = !lt_u;
            default: cmp_taken = 1'b0;
        endcase
    end

    always_comb
    begin
        logic taken;
        taken             = 1'b0;
        res.alu_result    = '0;
        res.branch_target = '0;
        res.side_data     = '0;
        res.is_load       = 1'b0;
        case (op.action)
            OPC_LUI:   res.alu_result = a;
            OPC_AUIPC: res.alu_result = sum;
            OPC_JAL:   res.alu_result = a;
            OPC_JALR:
            begin
                // bit 0 of the target is kept
                res.branch_target = sum;
                taken             = 1'b1;
                res.alu_result    = op.pc + INSN_BYTES;
            end
            OPC_BRANCH:
            begin
                res.branch_target = op.pc + op.third;
                taken             = cmp_taken;
            end
            OPC_LOAD:
            begin
                res.is_load    = 1'b1;
                res.alu_result = sum;
            end
            OPC_STORE:
            begin
                res.side_data  = op.third;
                res.alu_result = sum;
            end
            OPC_OPIMM: res.alu_result = alu_val;
            OPC_OP:
            begin
                // drop M-extension operations
                if (!op.funct7[0])
                begin
                    res.alu_result = alu_val;
                end
            end
            OPC_SYSTEM:
            begin
                case (op.funct3)
                    F3_CSRRW, F3_CSRRWI:
                    begin
                        res.side_data  = b;
                        res.alu_result = a;
                    end
                    F3_CSRRS, F3_CSRRSI:
                    begin
                        res.side_data  = a | b;
                        res.alu_result = a;
                    end
                    F3_CSRRC, F3_CSRRCI:
                    begin
                        res.side_data  = a & ~b;
                        res.alu_result = a;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        res.branch_taken = taken & op.item_valid;
        res.dest_reg     = op.dest_reg;
        res.dest_write   = op.dest_used & op.item_valid;
        res.valid        = op.item_valid;
    end

endmodule

`default_nettype wire

// ===== src/rv32i_execute_unit.sv =====
`default_nettype none

// Each accepted beat passes the input register, then the result register.
// Throughput: one beat per cycle while out_ready is high; the input register and the result register
// each hold one beat, so a new beat can be taken while a result still waits.
// Reset (rst_n low, asynchronous) empties both registers; no other state.
module rv32i_execute_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [6:0]  action,
    input  wire logic [2:0]  funct3_field,
    input  wire logic [6:0]  funct7_field,
    input  wire logic signed [31:0] left_operand,
    input  wire logic signed [31:0] right_operand,
    input  wire logic signed [31:0] third_operand,
    input  wire logic [31:0] pc_value,
    input  wire logic        item_valid,
    input  wire logic        dest_used,
    input  wire logic [4:0]  dest_reg,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      alu_result,
    output logic [31:0]      branch_target,
    output logic             branch_taken,
    output logic [31:0]      side_data,
    output logic             is_load,
    output logic [4:0]       dest_reg_out,
    output logic             dest_write,
    output logic             valid_out
);
    import rv32ex_pkg::*;

    logic s1_valid_reg;
    logic s1_valid_next;
    op_t  s1_op_reg;
    logic s2_valid_reg;
    logic s2_valid_next;
    res_t s2_res_reg;
    res_t s1_res;
    logic s1_advance;

    assign s1_advance    = s1_valid_reg && (!s2_valid_reg || out_ready);
    assign in_ready      = !s1_valid_reg || s1_advance;
    assign s1_valid_next = (in_valid && in_ready) || (s1_valid_reg && !s1_advance);
    assign s2_valid_next = s1_advance || (s2_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_op_reg.action     <= action;
            s1_op_reg.funct3     <= funct3_field;
            s1_op_reg.funct7     <= funct7_field;
            s1_op_reg.left       <= $unsigned(left_operand);
            s1_op_reg.right      <= $unsigned(right_operand);
            s1_op_reg.third      <= $unsigned(third_operand);
            s1_op_reg.pc         <= pc_value;
            s1_op_reg.item_valid <= item_valid;
            s1_op_reg.dest_used  <= dest_used;
            s1_op_reg.dest_reg   <= dest_reg;
        end
        // hold the result while the sink stalls
        if (s1_advance)
        begin
            s2_res_reg <= s1_res;
        end
    end

    rv32ex_alu u_alu (
        .op  (s1_op_reg),
        .res (s1_res)
    );

    assign out_valid     = s2_valid_reg;
    assign alu_result    = s2_res_reg.alu_result;
    assign branch_target = s2_res_reg.branch_target;
    assign branch_taken  = s2_res_reg.branch_taken;
    assign side_data     = s2_res_reg.side_data;
    assign is_load       = s2_res_reg.is_load;
    assign dest_reg_out  = s2_res_reg.dest_reg;
    assign dest_write    = s2_res_reg.dest_write;
    assign valid_out     = s2_res_reg.valid;

endmodule

`default_nettype wire

// ===== tb/sv/rv32i_execute_unit_tb.sv =====
`timescale 1ns / 1ps

module rv32i_execute_unit_tb;
    import rv32ex_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned STALL_CYCLES = 150;

    localparam logic [6:0] OPC_MISC_MEM = 7'h0F;
    localparam logic [6:0] OPC_CUSTOM_3 = 7'h7B;
    localparam logic [2:0] F3_NONE      = 3'd0;
    localparam logic [2:0] F3_PRIV      = 3'd0;
    localparam logic [2:0] F3_SYS_RSVD  = 3'd4;
    localparam logic [6:0] F7_NONE      = 7'h00;
    localparam logic [6:0] F7_ALT       = 7'h20;
    localparam logic [6:0] F7_MULDIV    = 7'h01;

    logic clk      = 1'b0;
    logic rst_n    = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    op_t  in_op    = '0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] alu_result;
    logic [31:0] branch_target;
    logic        branch_taken;
    logic [31:0] side_data;
    logic        is_load;
    logic [4:0]  dest_reg_out;
    logic        dest_write;
    logic        valid_out;

    res_t        results_due[$];
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned stall_len   = 0;
    int unsigned stall_id    = 0;
    int unsigned stall_seen  = 0;
    int unsigned stall_left  = 0;
    int unsigned beats_sent  = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count  = 0;
    int unsigned cycle_count     = 0;

    rv32i_execute_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (in_op.action),
        .funct3_field  (in_op.funct3),
        .funct7_field  (in_op.funct7),
        .left_operand  (in_op.left),
        .right_operand (in_op.right),
        .third_operand (in_op.third),
        .pc_value      (in_op.pc),
        .item_valid    (in_op.item_valid),
        .dest_used     (in_op.dest_used),
        .dest_reg      (in_op.dest_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .alu_result    (alu_result),
        .branch_target (branch_target),
        .branch_taken  (branch_taken),
        .side_data     (side_data),
        .is_load       (is_load),
        .dest_reg_out  (dest_reg_out),
        .dest_write    (dest_write),
        .valid_out     (valid_out)
    );

    always #2 clk = ~clk;

    // ALU value of the OP and OP-IMM groups; funct7 bit 5 picks SUB (register form) and SRA
    function automatic logic [31:0] alu_value(logic [2:0] f3, logic [6:0] f7,
                                              logic [31:0] a, logic [31:0] b, bit reg_form);
        logic [4:0] sh;
        logic [31:0] r;
        sh = b[4:0];
        case (f3)
            F3_ADD:  r = (reg_form && f7[5]) ? a - b : a + b;
            F3_SLL:  r = a << sh;
            F3_SLT:  r = {31'd0, ($signed(a) < $signed(b))};
            F3_SLTU: r = {31'd0, (a < b)};
            F3_XOR:  r = a ^ b;
            F3_SR:   r = f7[5] ? $unsigned($signed(a) >>> sh) : a >> sh;
            F3_OR:   r = a | b;
            default: r = a & b;
        endcase
        return r;
    endfunction

    function automatic res_t execute_op(op_t op);
        res_t r;
        r = '0;
        case (op.action)
            OPC_LUI, OPC_JAL: r.alu_result = op.left;
            OPC_AUIPC: r.alu_result = op.left + op.right;
            OPC_JALR:
            begin
                r.branch_target = op.left + op.right;
                r.branch_taken  = 1'b1;
                r.alu_result    = op.pc + INSN_BYTES;
            end
            OPC_BRANCH:
            begin
                r.branch_target = op.pc + op.third;
                case (op.funct3)
                    F3_BEQ:  r.branch_taken = (op.left == op.right);
                    F3_BNE:  r.branch_taken = (op.left != op.right);
                    F3_BLT:  r.branch_taken = ($signed(op.left) < $signed(op.right));
                    F3_BGE:  r.branch_taken = ($signed(op.left) >= $signed(op.right));
                    F3_BLTU: r.branch_taken = (op.left < op.right);
                    F3_BGEU: r.branch_taken = (op.left >= op.right);
                    default: r.branch_taken = 1'b0;
                endcase
            end
            OPC_LOAD:
            begin
                r.is_load    = 1'b1;
                r.alu_result = op.left + op.right;
            end
            OPC_STORE:
            begin
                r.side_data  = op.third;
                r.alu_result = op.left + op.right;
            end
            OPC_OPIMM: r.alu_result = alu_value(op.funct3, op.funct7, op.left, op.right, 1'b0);
            OPC_OP:
            begin
                // funct7 bit 0 marks multiply/divide, which this stage leaves at zero
                if (!op.funct7[0])
                    r.alu_result = alu_value(op.funct3, op.funct7, op.left, op.right, 1'b1);
            end
            OPC_SYSTEM:
            begin
                case (op.funct3)
                    F3_CSRRW, F3_CSRRWI:
                    begin
                        r.side_data  = op.right;
                        r.alu_result = op.left;
                    end
                    F3_CSRRS, F3_CSRRSI:
                    begin
                        r.side_data  = op.left | op.right;
                        r.alu_result = op.left;
                    end
                    F3_CSRRC, F3_CSRRCI:
                    begin
                        r.side_data  = op.left & ~op.right;
                        r.alu_result = op.left;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (!op.item_valid)
            r.branch_taken = 1'b0;
        r.dest_reg   = op.dest_reg;
        r.dest_write = op.dest_used & op.item_valid;
        r.valid      = op.item_valid;
        return r;
    endfunction

    function automatic op_t make_op(logic [6:0] action, logic [2:0] f3, logic [6:0] f7,
                                    logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                    logic [31:0] pc);
        op_t op;
        op.action     = action;
        op.funct3     = f3;
        op.funct7     = f7;
        op.left       = a;
        op.right      = b;
        op.third      = c;
        op.pc         = pc;
        op.item_valid = 1'b1;
        op.dest_used  = 1'b1;
        op.dest_reg   = 5'($urandom_range(31));
        return op;
    endfunction

    // Operand values biased towards the corners of the 32-bit range
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        case ($urandom_range(7))
            0: w = 32'h0000_0000;
            1: w = 32'h7FFF_FFFF;
            2: w = 32'h8000_0000;
            3: w = 32'hFFFF_FFFF;
            4: w = 32'($urandom_range(64));
            5: w = -32'($urandom_range(64));
            default: w = $urandom;
        endcase
        return w;
    endfunction

    function automatic op_t random_op();
        op_t op;
        logic [6:0] f7;
        case ($urandom_range(3))
            0: f7 = F7_NONE;
            1: f7 = F7_ALT;
            2: f7 = F7_MULDIV;
            default: f7 = 7'($urandom_range(127));
        endcase
        op = make_op(OPC_OP, 3'($urandom_range(7)), f7, pick_word(), pick_word(),
                     pick_word(), ($urandom_range(15) == 0) ? 32'hFFFF_FFFC : $urandom);
        case ($urandom_range(13))
            0: op.action = OPC_LUI;
            1: op.action = OPC_AUIPC;
            2: op.action = OPC_JAL;
            3: op.action = OPC_JALR;
            4, 5: op.action = OPC_BRANCH;
            6: op.action = OPC_LOAD;
            7: op.action = OPC_STORE;
            8, 9: op.action = OPC_OPIMM;
            10: op.action = OPC_SYSTEM;
            11: op.action = OPC_MISC_MEM;
            12: op.action = 7'($urandom_range(127));
            default: ;
        endcase
        // equal operands make branch and compare outcomes less one-sided
        if ($urandom_range(3) == 0)
            op.right = op.left;
        op.item_valid = ($urandom_range(9) != 0);
        op.dest_used  = 1'($urandom_range(1));
        return op;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %08h want %08h", name, got, want));
    endtask

    task automatic check_result();
        res_t want;
        if (results_due.size() == 0)
        begin
            report_mismatch("result beat with nothing outstanding");
        end
        else
        begin
            want = results_due.pop_front();
            compare_field("alu_result", alu_result, want.alu_result);
            compare_field("branch_target", branch_target, want.branch_target);
            compare_field("branch_taken", 32'(branch_taken), 32'(want.branch_taken));
            compare_field("side_data", side_data, want.side_data);
            compare_field("is_load", 32'(is_load), 32'(want.is_load));
            compare_field("dest_reg_out", 32'(dest_reg_out), 32'(want.dest_reg));
            compare_field("dest_write", 32'(dest_write), 32'(want.dest_write));
            compare_field("valid_out", 32'(valid_out), 32'(want.valid));
            results_checked++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_result();
    end

    // Output side: random back-pressure, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (stall_id != stall_seen)
            begin
                stall_seen = stall_id;
                stall_left = stall_len;
            end
            if (stall_left != 0)
            begin
                stall_left = stall_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_op(op_t op);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_op    <= op;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        results_due.push_back(execute_op(op));
        beats_sent++;
    endtask

    // Hold the input until every outstanding result has been seen
    task automatic drain_results();
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed();
        op_t op;
        int f3;
        tx_idle_pct = 16;
        rx_idle_pct = 54;
        send_op(make_op(OPC_LUI, F3_NONE, F7_NONE, 32'hFFFF_F000, 32'h0, 32'h0, 32'h0));
        send_op(make_op(OPC_AUIPC, F3_NONE, F7_NONE, 32'h7FFF_F000, 32'h7FFF_FFFF,
                        32'h0, 32'h0));
        // jump to x0: write enable still follows dest_used
        op = make_op(OPC_JAL, F3_NONE, F7_NONE, 32'h0000_1004, 32'h0, 32'h0, 32'h1000);
        op.dest_reg = 5'd0;
        send_op(op);
        // odd JALR target keeps bit 0; return address wraps
        send_op(make_op(OPC_JALR, F3_NONE, F7_NONE, 32'h0000_1001, 32'h0, 32'h0,
                        32'hFFFF_FFFC));
        op = make_op(OPC_JALR, F3_NONE, F7_NONE, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0,
                     32'h0000_0010);
        op.item_valid = 1'b0;
        send_op(op);
        // every branch funct3, including the two undefined ones
        for (f3 = 0; f3 < 8; f3++)
            send_op(make_op(OPC_BRANCH, 3'(f3), F7_NONE, 32'h8000_0000,
                            f3[0] ? 32'h7FFF_FFFF : 32'h8000_0000, 32'hFFFF_FFF0,
                            32'h0000_0008));
        op = make_op(OPC_LOAD, F3_NONE, F7_NONE, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 32'h0);
        op.item_valid = 1'b0;
        send_op(op);
        send_op(make_op(OPC_STORE, F3_NONE, F7_NONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'hFFFF_FFFF, 32'h0));
        send_op(make_op(OPC_OPIMM, F3_SR, F7_ALT, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0));
        send_op(make_op(OPC_OPIMM, F3_ADD, F7_ALT, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0, 32'h0));
        send_op(make_op(OPC_OP, F3_ADD, F7_ALT, 32'h8000_0000, 32'h0000_0001, 32'h0, 32'h0));
        send_op(make_op(OPC_OP, F3_SLL, F7_NONE, 32'hFFFF_FFFF, 32'h0000_0021, 32'h0, 32'h0));
        send_op(make_op(OPC_OP, F3_SLT, F7_NONE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0));
        send_op(make_op(OPC_OP, F3_XOR, F7_MULDIV, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0, 32'h0));
        send_op(make_op(OPC_SYSTEM, F3_PRIV, F7_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0));
        send_op(make_op(OPC_SYSTEM, F3_SYS_RSVD, F7_NONE, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0));
        send_op(make_op(OPC_SYSTEM, F3_CSRRW, F7_NONE, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0, 32'h0));
        send_op(make_op(OPC_SYSTEM, F3_CSRRSI, F7_NONE, 32'h0000_00F0, 32'h0000_000F, 32'h0, 32'h0));
        send_op(make_op(OPC_SYSTEM, F3_CSRRC, F7_NONE, 32'hFFFF_FFFF, 32'h8000_0001, 32'h0, 32'h0));
        send_op(make_op(OPC_MISC_MEM, F3_NONE, F7_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_op(make_op(OPC_CUSTOM_3, F3_NONE, F7_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF));
        drain_results();
    endtask

    task automatic test_random(int unsigned count, int unsigned tx_pct, int unsigned rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) send_op(random_op());
    endtask

    // Stop the output for a long stretch while beats keep coming, so the input stalls
    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stall_len   = STALL_CYCLES;
        stall_id++;
        repeat (40) send_op(random_op());
        drain_results();
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("[rv32i_execute_unit] ERROR");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(170, 16, 54);
        test_random(170, 54, 16);
        test_output_stall();
        test_random(150, 0, 0);
        drain_results();
        $display("%0d beats sent: corner cases of every opcode group, then random mixes",
                 beats_sent);
        $display("under three idle patterns and one long output stall; %0d results, %0d bad",
                 results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("[rv32i_execute_unit] OK");
        else
            $display("[rv32i_execute_unit] ERROR");
        $finish;
    end

endmodule
